// ----- hdl/fwn2a_pkg.sv -----
// fwn2a_pkg: shared types, constants and helpers for the fixed-width number to ascii block
// no dependencies; used by hdl/fixed_width_number_to_ascii.sv
`default_nettype none

package fwn2a_pkg;

    // display modes carried in the slave-side tuser
    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BIN  = 2'd3
    } t_opcode;

    // controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    // field widths of the stream beats
    localparam int unsigned LINE_W   = 3;
    localparam int unsigned COL_W    = 5;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned OCOL_W   = 7;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 24;

    // digit store: one 4-bit digit per shown position
    localparam int unsigned MAX_DIGITS = 32;
    localparam int unsigned DIG_IDX_W  = 5;

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    // decimal and hex digit to its ascii character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
        logic [CHAR_W-1:0] code;
        if (d < 4'd10) begin
            code = CHAR_ZERO + {3'b000, d};
        end else begin
            code = CHAR_UPPER + {3'b000, d - 4'd10};
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fixed_width_number_to_ascii.sv -----
// fixed_width_number_to_ascii: number to fixed-width ascii text, one character per beat
// depends on hdl/fwn2a_pkg.sv
`default_nettype none

// Takes one number per slave beat and sends its text on the master side, one character
// per beat, most significant digit first, each with its line and column, tlast on the
// final character. Unsigned and signed decimal, uppercase hex and binary are supported;
// the lowest digit_count digits (at most 32) are shown with leading zeros, and signed
// mode puts '+' or '-' in front of the magnitude. An item is loaded, then passes the
// bit-serial converter (one bit of the number shifted into the digit store per cycle,
// with add-3 correction in decimal), then goes out one character per cycle when the
// master side keeps tready high. A zero digit count in an unsigned, hex or binary item
// produces no beat. The slave side is ready while the converter is idle, which includes
// the time the final character waits on the master side.
module fixed_width_number_to_ascii #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave side
    input  wire logic                               i_s_axis_tvalid,
    output      logic                               o_s_axis_tready,
    // tdata: line[2:0], column[7:3], value[39:8], digit_count[45:40], zero[47:46]
    input  wire logic [fwn2a_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]                         i_s_axis_tuser,
    // master side
    output      logic                               o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: out_line[2:0], out_column[9:3], char_code[16:10], zero[23:17]
    output      logic [fwn2a_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    output      logic                               o_m_axis_tlast
);

    localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int unsigned DIG_BITS  = 4 * fwn2a_pkg::MAX_DIGITS;

    // slave beat fields
    logic [fwn2a_pkg::LINE_W-1:0] w_line;
    logic [fwn2a_pkg::COL_W-1:0]  w_column;
    logic [fwn2a_pkg::VAL_W-1:0]  w_value;
    logic [fwn2a_pkg::CNT_W-1:0]  w_count;
    fwn2a_pkg::t_opcode           w_opcode;

    assign w_line   = i_s_axis_tdata[2:0];
    assign w_column = i_s_axis_tdata[7:3];
    assign w_value  = i_s_axis_tdata[39:8];
    assign w_count  = i_s_axis_tdata[45:40];
    assign w_opcode = fwn2a_pkg::t_opcode'(i_s_axis_tuser);

    // registers
    fwn2a_pkg::t_state              r_state, n_state;
    fwn2a_pkg::t_opcode             r_opcode, n_opcode;
    logic [VALUE_BITS-1:0]          r_val, n_val;
    logic [BIT_CNT_W-1:0]           r_bit_cnt, n_bit_cnt;
    logic [DIG_BITS-1:0]            r_dig, n_dig;
    logic [fwn2a_pkg::CNT_W-1:0]    r_rem, n_rem;
    logic                           r_sign_pend, n_sign_pend;
    logic                           r_neg, n_neg;
    logic [fwn2a_pkg::LINE_W-1:0]   r_line, n_line;
    logic [fwn2a_pkg::OCOL_W-1:0]   r_col, n_col;
    logic                           r_m_valid, n_m_valid;
    logic [fwn2a_pkg::M_DATA_W-1:0] r_m_data, n_m_data;
    logic                           r_m_last, n_m_last;

    // number masked to VALUE_BITS and its magnitude in signed mode
    logic [63:0]                    w_ext;
    logic [VALUE_BITS-1:0]          w_v;
    logic                           w_neg;
    logic [VALUE_BITS-1:0]          w_mag;
    logic [fwn2a_pkg::CNT_W-1:0]    w_count_sat;

    assign w_ext       = {32'd0, w_value};
    assign w_v         = w_ext[VALUE_BITS-1:0];
    assign w_neg       = (w_opcode == fwn2a_pkg::OP_SDEC) && w_v[VALUE_BITS-1];
    assign w_mag       = w_neg ? (~w_v + 1'b1) : w_v;
    assign w_count_sat = (w_count > fwn2a_pkg::CNT_W'(fwn2a_pkg::MAX_DIGITS))
                       ? fwn2a_pkg::CNT_W'(fwn2a_pkg::MAX_DIGITS) : w_count;

    // one converter step: shift the next bit of the number into the digit store
    logic                  w_in_bit;
    logic [DIG_BITS-1:0]   w_adj;
    logic [DIG_BITS-1:0]   w_step;

    assign w_in_bit = r_val[VALUE_BITS-1];

    always_comb begin
        w_adj  = r_dig;
        w_step = r_dig;
        case (r_opcode)
            fwn2a_pkg::OP_UDEC, fwn2a_pkg::OP_SDEC: begin
                for (int k = 0; k < fwn2a_pkg::MAX_DIGITS; k++) begin
                    if (r_dig[4*k +: 4] >= 4'd5) begin
                        w_adj[4*k +: 4] = r_dig[4*k +: 4] + 4'd3;
                    end
                end
                w_step = {w_adj[DIG_BITS-2:0], w_in_bit};
            end
            fwn2a_pkg::OP_HEX: begin
                w_step = {r_dig[DIG_BITS-2:0], w_in_bit};
            end
            fwn2a_pkg::OP_BIN: begin
                w_step = '0;
                w_step[0] = w_in_bit;
                for (int k = 1; k < fwn2a_pkg::MAX_DIGITS; k++) begin
                    w_step[4*k] = r_dig[4*(k-1)];
                end
            end
            default: begin
                w_step = r_dig;
            end
        endcase
    end

    // digit to show next: most significant remaining position
    logic [fwn2a_pkg::DIG_IDX_W-1:0] w_dig_idx;
    logic [fwn2a_pkg::CNT_W-1:0]     w_rem_dec;
    logic [3:0]                      w_dig;
    logic                            w_out_free;

    assign w_rem_dec  = r_rem - 1'b1;
    assign w_dig_idx  = w_rem_dec[fwn2a_pkg::DIG_IDX_W-1:0];
    assign w_dig      = r_dig[4*w_dig_idx +: 4];
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    // controller
    always_comb begin
        n_state     = r_state;
        n_opcode    = r_opcode;
        n_val       = r_val;
        n_bit_cnt   = r_bit_cnt;
        n_dig       = r_dig;
        n_rem       = r_rem;
        n_sign_pend = r_sign_pend;
        n_neg       = r_neg;
        n_line      = r_line;
        n_col       = r_col;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        n_m_last    = r_m_last;

        // master beat taken
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            fwn2a_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_opcode    = w_opcode;
                    n_val       = w_mag;
                    n_bit_cnt   = '0;
                    n_dig       = '0;
                    n_rem       = w_count_sat;
                    n_sign_pend = (w_opcode == fwn2a_pkg::OP_SDEC);
                    n_neg       = w_neg;
                    n_line      = w_line;
                    n_col       = {2'b00, w_column};
                    if ((w_count_sat != '0) || (w_opcode == fwn2a_pkg::OP_SDEC)) begin
                        n_state = fwn2a_pkg::ST_CONV;
                    end
                end
            end
            fwn2a_pkg::ST_CONV: begin
                n_dig     = w_step;
                n_val     = {r_val[VALUE_BITS-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == BIT_CNT_W'(VALUE_BITS - 1)) begin
                    n_state = fwn2a_pkg::ST_EMIT;
                end
            end
            fwn2a_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_col     = r_col + 1'b1;
                    if (r_sign_pend) begin
                        n_sign_pend = 1'b0;
                        n_m_data    = {7'd0,
                                       r_neg ? fwn2a_pkg::CHAR_MINUS : fwn2a_pkg::CHAR_PLUS,
                                       r_col, r_line};
                        n_m_last    = (r_rem == '0);
                        if (r_rem == '0) begin
                            n_state = fwn2a_pkg::ST_IDLE;
                        end
                    end else begin
                        n_rem    = w_rem_dec;
                        n_m_data = {7'd0, fwn2a_pkg::digit_to_ascii(w_dig), r_col, r_line};
                        n_m_last = (r_rem == fwn2a_pkg::CNT_W'(1));
                        if (r_rem == fwn2a_pkg::CNT_W'(1)) begin
                            n_state = fwn2a_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = fwn2a_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fwn2a_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_opcode    <= n_opcode;
        r_val       <= n_val;
        r_bit_cnt   <= n_bit_cnt;
        r_dig       <= n_dig;
        r_rem       <= n_rem;
        r_sign_pend <= n_sign_pend;
        r_neg       <= n_neg;
        r_line      <= n_line;
        r_col       <= n_col;
        r_m_data    <= n_m_data;
        r_m_last    <= n_m_last;
    end

    assign o_s_axis_tready = (r_state == fwn2a_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

// ----- tb/fixed_width_number_to_ascii_tb.sv -----
// fixed_width_number_to_ascii_tb: self-checking bench for the number to ascii text block
// depends on hdl/fwn2a_pkg.sv and hdl/fixed_width_number_to_ascii.sv
// directed corner numbers, then random numbers under random stalls on both stream sides
module fixed_width_number_to_ascii_tb;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned NUMBERS_WANTED = 250;

    // field widths of the stream beats
    localparam int unsigned LINE_W     = fwn2a_pkg::LINE_W;
    localparam int unsigned COL_W      = fwn2a_pkg::COL_W;
    localparam int unsigned VAL_W      = fwn2a_pkg::VAL_W;
    localparam int unsigned CNT_W      = fwn2a_pkg::CNT_W;
    localparam int unsigned OCOL_W     = fwn2a_pkg::OCOL_W;
    localparam int unsigned CHAR_W     = fwn2a_pkg::CHAR_W;
    localparam int unsigned S_DATA_W   = fwn2a_pkg::S_DATA_W;
    localparam int unsigned M_DATA_W   = fwn2a_pkg::M_DATA_W;
    localparam int unsigned MAX_DIGITS = fwn2a_pkg::MAX_DIGITS;

    // one expected character beat
    typedef struct {
        logic [LINE_W-1:0]  out_line;
        logic [OCOL_W-1:0]  out_column;
        logic [CHAR_W-1:0]  code;
        logic               last;
    } t_char_beat;

    // predicts the text of each accepted number and checks the characters against it
    class t_text_scoreboard;
        t_char_beat pending_chars[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void push_char(logic [LINE_W-1:0] ln, logic [OCOL_W-1:0] col,
                                logic [CHAR_W-1:0] code, logic last);
            t_char_beat b;
            b.out_line = ln;
            b.out_column = col;
            b.code = code;
            b.last = last;
            pending_chars.push_back(b);
        endfunction

        // work out the characters that one accepted number should produce
        function void note_number(fwn2a_pkg::t_opcode op, logic [LINE_W-1:0] ln,
                                  logic [COL_W-1:0] col, logic [VAL_W-1:0] value,
                                  logic [CNT_W-1:0] cnt);
            int unsigned n_digits;
            int unsigned offset;
            int unsigned radix;
            logic [VAL_W-1:0] mag;
            logic [63:0] rem;
            logic [3:0] digs [0:MAX_DIGITS-1];
            logic [3:0] d;
            logic [CHAR_W-1:0] code;
            n_digits = (cnt > MAX_DIGITS) ? MAX_DIGITS : cnt;
            mag = value;
            offset = 0;
            // signed mode: sign first, then the magnitude
            if (op == fwn2a_pkg::OP_SDEC) begin
                if (value[VAL_W-1]) begin
                    mag = ~value + 1'b1;
                end
                push_char(ln, OCOL_W'(col),
                          value[VAL_W-1] ? fwn2a_pkg::CHAR_MINUS : fwn2a_pkg::CHAR_PLUS,
                          n_digits == 0);
                offset = 1;
            end
            case (op)
                fwn2a_pkg::OP_HEX: radix = 16;
                fwn2a_pkg::OP_BIN: radix = 2;
                default:           radix = 10;
            endcase
            // digits least significant first
            rem = 64'(mag);
            for (int i = 0; i < int'(n_digits); i++) begin
                digs[i] = 4'(rem % radix);
                rem = rem / radix;
            end
            // emitted most significant first
            for (int i = 0; i < int'(n_digits); i++) begin
                d = digs[int'(n_digits) - 1 - i];
                code = (d < 4'd10) ? fwn2a_pkg::CHAR_ZERO + CHAR_W'(d)
                                   : fwn2a_pkg::CHAR_UPPER + CHAR_W'(d - 4'd10);
                push_char(ln, OCOL_W'(col + offset + i), code, i + 1 == int'(n_digits));
            end
        endfunction

        function void check_char(logic [LINE_W-1:0] ln, logic [OCOL_W-1:0] col,
                                 logic [CHAR_W-1:0] code, logic last);
            t_char_beat b;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, %s %0d col %0d code %0h %s %0b",
                         $time, "actual line", ln, col, code, "last", last);
                errors++;
                return;
            end
            b = pending_chars.pop_front();
            if (ln !== b.out_line) begin
                $display("%0t: line mismatch, expected %0d, actual %0d", $time, b.out_line, ln);
                errors++;
            end
            if (col !== b.out_column) begin
                $display("%0t: column mismatch, expected %0d, actual %0d",
                         $time, b.out_column, col);
                errors++;
            end
            if (code !== b.code) begin
                $display("%0t: char mismatch, expected %0h, actual %0h", $time, b.code, code);
                errors++;
            end
            if (last !== b.last) begin
                $display("%0t: tlast mismatch, expected %0b, actual %0b", $time, b.last, last);
                errors++;
            end
        endfunction

        function int waiting();
            return pending_chars.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic [1:0]             s_tuser = fwn2a_pkg::OP_UDEC;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire  [M_DATA_W-1:0]    m_tdata;
    wire                    m_tlast;

    t_text_scoreboard board;
    bit quiet_tail = 1'b0;
    bit hold_request = 1'b0;
    int unsigned idle_cycles = 0;

    fixed_width_number_to_ascii dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // offer one number and note it once the beat is taken
    task automatic offer_number(input fwn2a_pkg::t_opcode op, input logic [LINE_W-1:0] ln,
                                input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value,
                                input logic [CNT_W-1:0] cnt);
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, cnt, value, col, ln};
        s_tuser <= op;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        board.note_number(op, ln, col, value, cnt);
        // occasional gap on the sending side
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // random number, biased towards the corner values
    task automatic offer_random_number(output bit shows_text);
        fwn2a_pkg::t_opcode op;
        logic [CNT_W-1:0] cnt;
        logic [VAL_W-1:0] value;
        int unsigned pick;
        op = fwn2a_pkg::t_opcode'($urandom_range(0, 3));
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            cnt = '0;
        end else if (pick == 1) begin
            cnt = CNT_W'($urandom_range(MAX_DIGITS + 1, 63));
        end else begin
            cnt = CNT_W'($urandom_range(1, MAX_DIGITS));
        end
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            2:       value = 32'h8000_0000;
            3:       value = 32'h7FFF_FFFF;
            4:       value = $urandom_range(0, 999);
            default: value = $urandom;
        endcase
        offer_number(op, LINE_W'($urandom), COL_W'($urandom), value, cnt);
        shows_text = !(cnt == 0 && op != fwn2a_pkg::OP_SDEC);
    endtask

    // stop sending until every character has come out
    task automatic drain_text();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.waiting() != 0) @(posedge i_clk);
    endtask

    // receiving side: check each character beat, stall in bursts or on a long hold
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit hold_taken;
        stall_left = 0;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rst_n && m_tvalid === 1'b1 && m_tready) begin
                board.check_char(m_tdata[2:0], m_tdata[9:3], m_tdata[16:10], m_tlast);
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("fixed_width_number_to_ascii_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        int unsigned shown;
        bit shows_text;
        board = new();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: extremes, every mode, saturation, zero count, most negative
        offer_number(fwn2a_pkg::OP_UDEC, 3'd1, 5'd1, 32'hFFFF_FFFF, 6'd10);
        offer_number(fwn2a_pkg::OP_UDEC, 3'd2, 5'd4, 32'hFFFF_FFFF, 6'd32);
        offer_number(fwn2a_pkg::OP_UDEC, 3'd3, 5'd2, 32'd12345, 6'd0);
        offer_number(fwn2a_pkg::OP_UDEC, 3'd4, 5'd16, 32'd4000000000, 6'd63);
        offer_number(fwn2a_pkg::OP_UDEC, 3'd0, 5'd0, 32'd0, 6'd1);
        offer_number(fwn2a_pkg::OP_SDEC, 3'd1, 5'd1, 32'h8000_0000, 6'd10);
        offer_number(fwn2a_pkg::OP_SDEC, 3'd2, 5'd3, 32'd0, 6'd3);
        offer_number(fwn2a_pkg::OP_SDEC, 3'd3, 5'd5, 32'hFFFF_FF85, 6'd0);
        offer_number(fwn2a_pkg::OP_SDEC, 3'd4, 5'd7, 32'h7FFF_FFFF, 6'd10);
        offer_number(fwn2a_pkg::OP_SDEC, 3'd7, 5'd31, 32'hFFFF_FFFF, 6'd2);
        offer_number(fwn2a_pkg::OP_SDEC, 3'd1, 5'd8, 32'h8000_0000, 6'd40);
        offer_number(fwn2a_pkg::OP_HEX, 3'd2, 5'd1, 32'hDEAD_BEEF, 6'd8);
        offer_number(fwn2a_pkg::OP_HEX, 3'd3, 5'd31, 32'hFFFF_FFFF, 6'd32);
        offer_number(fwn2a_pkg::OP_HEX, 3'd4, 5'd9, 32'h0123_ABCD, 6'd0);
        offer_number(fwn2a_pkg::OP_HEX, 3'd5, 5'd10, 32'h0123_ABCD, 6'd4);
        offer_number(fwn2a_pkg::OP_BIN, 3'd6, 5'd11, 32'hA5A5_A5A5, 6'd32);
        offer_number(fwn2a_pkg::OP_BIN, 3'd1, 5'd12, 32'h0000_0001, 6'd1);
        offer_number(fwn2a_pkg::OP_BIN, 3'd2, 5'd13, 32'h5A5A_5A5A, 6'd0);
        offer_number(fwn2a_pkg::OP_BIN, 3'd7, 5'd0, 32'h5A5A_5A5A, 6'd63);
        offer_number(fwn2a_pkg::OP_UDEC, 3'd0, 5'd31, 32'd9, 6'd33);

        // sender pause until the text is all out
        drain_text();

        // random numbers; long receiver hold mid-run, quiet tail at the end
        shown = 0;
        while (shown < NUMBERS_WANTED) begin
            if (shown == 100) begin
                hold_request = 1'b1;
            end
            if (shown == 170) begin
                drain_text();
            end
            if (shown >= NUMBERS_WANTED - 40) begin
                quiet_tail = 1'b1;
            end
            offer_random_number(shows_text);
            if (shows_text) begin
                shown++;
            end
        end
        s_tvalid <= 1'b0;

        // wait for the remaining text, then let the bench idle before the final check
        while (board.waiting() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.waiting() == 0) begin
            $display("fixed_width_number_to_ascii_tb: done, clean");
        end else begin
            $display("fixed_width_number_to_ascii_tb: done, errors");
        end
        $finish;
    end

endmodule
